// ===== src/inverse_cdf_table_sampler_assert.svh =====
// Assertion macros used by the inverse CDF sampler RTL.
// No dependencies; included by icts_back, the module that carries checks.
`ifndef INVERSE_CDF_TABLE_SAMPLER_ASSERT_SVH
`define INVERSE_CDF_TABLE_SAMPLER_ASSERT_SVH

// same-cycle implication, masked while in reset
`define ICTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("icts: same-cycle check failed");

// next-cycle implication, masked while in reset
`define ICTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("icts: next-cycle check failed");

`endif

// ===== src/icts_pkg.sv =====
// Shared types and constants of the inverse CDF table sampler.
// No dependencies.
package icts_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int ADDR_W_MAX      = 16;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_BELOW = 2'd1;
  localparam logic [1:0] STATUS_NONE  = 2'd2;

  localparam logic [2:0] CFG_MEAN_0   = 3'd0;
  localparam logic [2:0] CFG_MEAN_3   = 3'd3;
  localparam logic [2:0] CFG_SPREAD_0 = 3'd4;
  localparam logic [2:0] CFG_SPREAD_3 = 3'd7;

  typedef struct packed {
    logic                   is_draw;
    logic [ADDR_W_MAX-1:0]  addr;
    logic [24:0]            cdf;
    logic [31:0]            mag;
    logic [23:0]            u;
    logic [3:0][15:0]       gauss;
  } item_t;

  typedef enum logic [3:0] {
    BS_IDLE,
    BS_PROBE,
    BS_COMPARE,
    BS_RD_ONE,
    BS_GOT_ONE,
    BS_RD_HI,
    BS_RD_LO,
    BS_GOT_LO,
    BS_DIV,
    BS_MUL_LO,
    BS_MUL_HI,
    BS_COLOR,
    BS_EMIT
  } back_state_e;

endpackage

// ===== src/icts_front.sv =====
// Front end: takes items from the command port, drops out-of-range loads.
// Depends on icts_pkg.
module icts_front #(
  parameter int TABLE_DEPTH = icts_pkg::TABLE_DEPTH_DEF
) (
  input  logic                start_i,
  input  logic                queue_full_i,
  input  logic                op_i,
  input  logic [9:0]          entry_index_i,
  input  logic [24:0]         cdf_value_i,
  input  logic signed [31:0]  mag_value_i,
  input  logic [23:0]         uniform_sample_i,
  input  logic signed [15:0]  gauss_0_i,
  input  logic signed [15:0]  gauss_1_i,
  input  logic signed [15:0]  gauss_2_i,
  input  logic signed [15:0]  gauss_3_i,
  output logic                busy_o,
  output logic                push_o,
  output icts_pkg::item_t     item_o
);
  import icts_pkg::*;

  logic in_range;

  assign busy_o   = queue_full_i;
  assign in_range = 32'(entry_index_i) < 32'(TABLE_DEPTH);
  // a load past the table end is accepted and dropped here
  assign push_o   = start_i && !queue_full_i && ((op_i == OP_DRAW) || in_range);

  always_comb begin
    item_o.is_draw  = (op_i == OP_DRAW);
    item_o.addr     = ADDR_W_MAX'(entry_index_i);
    item_o.cdf      = cdf_value_i;
    item_o.mag      = mag_value_i;
    item_o.u        = uniform_sample_i;
    item_o.gauss[0] = gauss_0_i;
    item_o.gauss[1] = gauss_1_i;
    item_o.gauss[2] = gauss_2_i;
    item_o.gauss[3] = gauss_3_i;
  end

endmodule

// ===== src/icts_queue.sv =====
// Short item queue between front and back end.
// Depends on icts_pkg.
module icts_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  icts_pkg::item_t item_i,
  input  logic            pop_i,
  output icts_pkg::item_t head_o,
  output logic            empty_o,
  output logic            full_o
);
  import icts_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  item_t          mem_q [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]  cnt_q;
  logic           do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CW'(QUEUE_DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== src/icts_back.sv =====
// Back end: table memories, binary search, serial divider, interpolation
// and colour datapath. Depends on icts_pkg and the assertion macro header.
`include "inverse_cdf_table_sampler_assert.svh"

module icts_back #(
  parameter int TABLE_DEPTH = icts_pkg::TABLE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  icts_pkg::item_t     head_i,
  output logic                pop_o,
  input  logic [3:0][31:0]    mean_i,
  input  logic [3:0][31:0]    spread_i,
  output logic                valid_o,
  output logic signed [31:0]  magnitude_o,
  output logic signed [31:0]  color_out_0_o,
  output logic signed [31:0]  color_out_1_o,
  output logic signed [31:0]  color_out_2_o,
  output logic signed [31:0]  color_out_3_o,
  output logic [1:0]          status_o
);
  import icts_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = AW + 1;

  logic [24:0] cdf_mem [TABLE_DEPTH];
  logic [31:0] mag_mem [TABLE_DEPTH];

  back_state_e state_q, state_d;

  logic [CW-1:0]      lo_q, hi_q;
  logic [AW-1:0]      ia_q;
  logic [23:0]        u_q;
  logic [3:0][15:0]   gauss_q;
  logic [1:0]         status_q;
  logic [24:0]        cdfh_q, den_q;
  logic [25:0]        rem_q;
  logic [23:0]        quo_q;
  logic [4:0]         div_cnt_q;
  logic signed [31:0] m0_q, m1_q, mag_res_q;
  logic signed [56:0] acc_q;
  logic signed [48:0] prod_q;
  logic [2:0]         col_cnt_q;
  logic [3:0][31:0]   color_q;
  logic [24:0]        cdf_rd_q;
  logic [31:0]        mag_rd_q;

  logic [AW-1:0]      rd_addr;
  logic               mem_we;
  logic [CW:0]        mid_sum;
  logic [CW-1:0]      mid;
  logic               search_done;
  logic [25:0]        rem_sh;
  logic               q_bit;
  logic signed [32:0] diff;
  logic signed [12:0] mul_b;
  logic signed [45:0] pp;
  logic signed [56:0] mag_sum;
  logic [1:0]         ck;
  logic [1:0]         cw;
  logic signed [48:0] prod_d;
  logic signed [36:0] csum;

  assign mid_sum     = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid         = mid_sum[CW:1];
  assign search_done = (lo_q == hi_q);

  // restoring division step, remainder stays below the divisor
  assign rem_sh = {rem_q[24:0], 1'b0};
  assign q_bit  = (rem_sh >= {1'b0, den_q});

  // interpolation multiply split into two 12-bit halves of the fraction
  assign diff    = {m1_q[31], m1_q} - {m0_q[31], m0_q};
  assign mul_b   = (state_q == BS_MUL_HI) ? $signed({1'b0, quo_q[23:12]})
                                          : $signed({1'b0, quo_q[11:0]});
  assign pp      = diff * mul_b;
  assign mag_sum = (acc_q >>> 24) + 57'(m0_q);

  assign ck     = col_cnt_q[1:0];
  assign cw     = 2'(col_cnt_q - 3'd1);
  assign prod_d = $signed({1'b0, spread_i[ck]}) * $signed(gauss_q[ck]);
  assign csum   = 37'($signed(mean_i[cw])) + 37'(prod_q >>> 12);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BS_IDLE:    if (!empty_i && head_i.is_draw) state_d = BS_PROBE;
      BS_PROBE: begin
        if (!search_done) begin
          state_d = BS_COMPARE;
        end else if (lo_q == CW'(TABLE_DEPTH) || lo_q == '0) begin
          state_d = BS_RD_ONE;
        end else begin
          state_d = BS_RD_HI;
        end
      end
      BS_COMPARE: state_d = BS_PROBE;
      BS_RD_ONE:  state_d = BS_GOT_ONE;
      BS_GOT_ONE: state_d = BS_COLOR;
      BS_RD_HI:   state_d = BS_RD_LO;
      BS_RD_LO:   state_d = BS_GOT_LO;
      BS_GOT_LO:  state_d = BS_DIV;
      BS_DIV:     if (div_cnt_q == 5'd23) state_d = BS_MUL_LO;
      BS_MUL_LO:  state_d = BS_MUL_HI;
      BS_MUL_HI:  state_d = BS_COLOR;
      BS_COLOR:   if (col_cnt_q == 3'd4) state_d = BS_EMIT;
      BS_EMIT:    state_d = BS_IDLE;
      default:    state_d = BS_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    pop_o   = 1'b0;
    mem_we  = 1'b0;
    valid_o = 1'b0;
    rd_addr = mid[AW-1:0];
    unique case (state_q)
      BS_IDLE: begin
        pop_o  = !empty_i;
        mem_we = !empty_i && !head_i.is_draw;
      end
      BS_RD_ONE, BS_RD_HI: rd_addr = ia_q;
      BS_RD_LO:            rd_addr = ia_q - 1'b1;
      BS_EMIT:             valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cdf_mem[head_i.addr[AW-1:0]] <= head_i.cdf;
      mag_mem[head_i.addr[AW-1:0]] <= head_i.mag;
    end
    cdf_rd_q <= cdf_mem[rd_addr];
    mag_rd_q <= mag_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q      <= '0;
      hi_q      <= '0;
      div_cnt_q <= '0;
      col_cnt_q <= '0;
    end else begin
      case (state_q)
        BS_IDLE: begin
          lo_q <= '0;
          hi_q <= CW'(TABLE_DEPTH);
        end
        BS_COMPARE: begin
          if (cdf_rd_q > {1'b0, u_q}) begin
            hi_q <= mid;
          end else begin
            lo_q <= mid + 1'b1;
          end
        end
        BS_GOT_LO: div_cnt_q <= '0;
        BS_DIV:    div_cnt_q <= div_cnt_q + 1'b1;
        BS_COLOR:  col_cnt_q <= col_cnt_q + 1'b1;
        BS_EMIT:   col_cnt_q <= '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BS_IDLE: begin
        u_q     <= head_i.u;
        gauss_q <= head_i.gauss;
      end
      BS_PROBE: begin
        if (lo_q == CW'(TABLE_DEPTH)) begin
          status_q <= STATUS_NONE;
          ia_q     <= AW'(TABLE_DEPTH - 1);
        end else if (lo_q == '0) begin
          status_q <= STATUS_BELOW;
          ia_q     <= '0;
        end else begin
          status_q <= STATUS_OK;
          ia_q     <= lo_q[AW-1:0];
        end
      end
      BS_GOT_ONE: mag_res_q <= mag_rd_q;
      BS_RD_LO: begin
        cdfh_q <= cdf_rd_q;
        m1_q   <= mag_rd_q;
      end
      BS_GOT_LO: begin
        m0_q  <= mag_rd_q;
        rem_q <= {2'b00, u_q - cdf_rd_q[23:0]};
        den_q <= cdfh_q - cdf_rd_q;
      end
      BS_DIV: begin
        rem_q <= q_bit ? rem_sh - {1'b0, den_q} : rem_sh;
        quo_q <= {quo_q[22:0], q_bit};
      end
      BS_MUL_LO: acc_q <= 57'(pp);
      BS_MUL_HI: acc_q <= acc_q + (57'(pp) <<< 12);
      BS_COLOR: begin
        if (col_cnt_q == 3'd0 && status_q == STATUS_OK) begin
          mag_res_q <= mag_sum[31:0];
        end
        prod_q <= prod_d;
        if (col_cnt_q != 3'd0) begin
          // saturate to the signed 32-bit range
          if (csum[36:31] == 6'b000000 || csum[36:31] == 6'b111111) begin
            color_q[cw] <= csum[31:0];
          end else if (csum[36]) begin
            color_q[cw] <= 32'h8000_0000;
          end else begin
            color_q[cw] <= 32'h7fff_ffff;
          end
        end
      end
      default: ;
    endcase
  end

  assign magnitude_o   = mag_res_q;
  assign color_out_0_o = color_q[0];
  assign color_out_1_o = color_q[1];
  assign color_out_2_o = color_q[2];
  assign color_out_3_o = color_q[3];
  assign status_o      = status_q;

  `ICTS_ASSERT_IMP(a_search_bounds, clk_i, rst_ni, state_q == BS_COMPARE, lo_q < hi_q)
  `ICTS_ASSERT_IMP(a_div_rem, clk_i, rst_ni, state_q == BS_DIV, rem_q[24:0] < den_q)
  `ICTS_ASSERT_NXT(a_emit_once, clk_i, rst_ni, state_q == BS_EMIT, state_q == BS_IDLE)

endmodule

// ===== src/inverse_cdf_table_sampler.sv =====
// Inverse CDF table sampler: top level with configuration registers.
// Depends on icts_pkg, icts_front, icts_queue and icts_back.
//
// Usage: an item is taken when start_i is high and busy_o is low. op_i = 0
// loads entry entry_index_i of the CDF and magnitude tables (loads past the
// table end are dropped); op_i = 1 draws a sample with uniform_sample_i and
// gauss_0..3_i. Each draw gives one result, shown for exactly one cycle with
// valid_o high; the receiver cannot stall, so results are never held.
// A two-item queue sits between the command port and the execution unit, so
// busy_o only rises when two items are waiting.
// Steps: a load is written to the tables as it is popped. A draw is popped,
// binary-searched (each probe is one table read plus one compare), its two
// neighbouring entries fetched, the fraction found by the serial divider and
// applied by the split multiply, the colours formed and the result output.
// Draws below the first entry or past the last take the short path: one
// entry fetch, then colours and output. One item runs at a time; the serial
// divider and the search loop over the single table read port dominate.
// Reset clears control and config state; tables stay undefined until loaded.
module inverse_cdf_table_sampler #(
  parameter int TABLE_DEPTH = icts_pkg::TABLE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic                op_i,
  input  logic [9:0]          entry_index_i,
  input  logic [24:0]         cdf_value_i,
  input  logic signed [31:0]  mag_value_i,
  input  logic [23:0]         uniform_sample_i,
  input  logic signed [15:0]  gauss_0_i,
  input  logic signed [15:0]  gauss_1_i,
  input  logic signed [15:0]  gauss_2_i,
  input  logic signed [15:0]  gauss_3_i,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [31:0]         cfg_wdata_i,
  output logic                valid_o,
  output logic signed [31:0]  magnitude_o,
  output logic signed [31:0]  color_out_0_o,
  output logic signed [31:0]  color_out_1_o,
  output logic signed [31:0]  color_out_2_o,
  output logic signed [31:0]  color_out_3_o,
  output logic [1:0]          status_o
);
  import icts_pkg::*;

  logic [3:0][31:0] mean_q, spread_q;
  logic             push, pop, q_empty, q_full;
  item_t            push_item, head_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q   <= '0;
      spread_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i) inside
        [CFG_MEAN_0:CFG_MEAN_3]:     mean_q[cfg_idx_i[1:0]]   <= cfg_wdata_i;
        [CFG_SPREAD_0:CFG_SPREAD_3]: spread_q[cfg_idx_i[1:0]] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  icts_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .start_i          (start_i),
    .queue_full_i     (q_full),
    .op_i             (op_i),
    .entry_index_i    (entry_index_i),
    .cdf_value_i      (cdf_value_i),
    .mag_value_i      (mag_value_i),
    .uniform_sample_i (uniform_sample_i),
    .gauss_0_i        (gauss_0_i),
    .gauss_1_i        (gauss_1_i),
    .gauss_2_i        (gauss_2_i),
    .gauss_3_i        (gauss_3_i),
    .busy_o           (busy_o),
    .push_o           (push),
    .item_o           (push_item)
  );

  icts_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .head_o  (head_item),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  icts_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (q_empty),
    .head_i        (head_item),
    .pop_o         (pop),
    .mean_i        (mean_q),
    .spread_i      (spread_q),
    .valid_o       (valid_o),
    .magnitude_o   (magnitude_o),
    .color_out_0_o (color_out_0_o),
    .color_out_1_o (color_out_1_o),
    .color_out_2_o (color_out_2_o),
    .color_out_3_o (color_out_3_o),
    .status_o      (status_o)
  );

endmodule

// ===== test/inverse_cdf_table_sampler_checker.sv =====
// Checker for the inverse CDF table sampler: watches the command, config and result ports,
// predicts each draw from its own copy of the tables and registers, and counts mismatches.
// Depends on icts_pkg.
module inverse_cdf_table_sampler_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic               op_i,
  input  logic [9:0]         entry_index_i,
  input  logic [24:0]        cdf_value_i,
  input  logic signed [31:0] mag_value_i,
  input  logic [23:0]        uniform_sample_i,
  input  logic [3:0][15:0]   gauss_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               valid_i,
  input  logic signed [31:0] magnitude_i,
  input  logic [3:0][31:0]   color_i,
  input  logic [1:0]         status_i,
  output int                 errors_o,
  output int                 pending_o
);
  import icts_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;

  typedef struct packed {
    logic [31:0]      mag;
    logic [3:0][31:0] color;
    logic [1:0]       status;
  } sample_t;

  logic [24:0]        cdf_q  [DEPTH];
  logic signed [31:0] mag_q  [DEPTH];
  logic signed [31:0] mean_q [4];
  logic [31:0]        spread_q [4];
  sample_t            samples_due [$];

  assign pending_o = samples_due.size();

  function automatic sample_t shape_draw(logic [23:0] u, logic [3:0][15:0] g);
    sample_t r;
    int      hit;
    longint  lo, den, frac, m0, m1, c;
    hit = -1;
    for (int i = 0; i < DEPTH; i++)
      if (hit < 0 && cdf_q[i] > u) hit = i;
    if (hit < 0) begin
      r.mag = mag_q[DEPTH-1];
      r.status = STATUS_NONE;
    end else if (hit == 0) begin
      r.mag = mag_q[0];
      r.status = STATUS_BELOW;
    end else begin
      lo   = longint'(cdf_q[hit-1]);
      den  = longint'(cdf_q[hit]) - lo;
      frac = ((longint'(u) - lo) <<< 24) / den;
      m0   = longint'(mag_q[hit-1]);
      m1   = longint'(mag_q[hit]);
      r.mag = 32'(m0 + (((m1 - m0) * frac) >>> 24));
      r.status = STATUS_OK;
    end
    for (int k = 0; k < 4; k++) begin
      c = longint'(mean_q[k]) +
          ((longint'({32'b0, spread_q[k]}) * longint'($signed(g[k]))) >>> 12);
      if (c > 64'sd2147483647) c = 64'sd2147483647;
      if (c < -64'sd2147483648) c = -64'sd2147483648;
      r.color[k] = 32'(c);
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sample_t want, got;
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) begin
        mean_q[k] = '0;
        spread_q[k] = '0;
      end
      samples_due.delete();
      errors_o <= 0;
    end else begin
      if (valid_i) begin
        got.mag = magnitude_i;
        got.color = color_i;
        got.status = status_i;
        if (samples_due.size() == 0) begin
          if (errors_o < 10) $display("unexpected result: mag %h status %0d", got.mag, got.status);
          errors_o <= errors_o + 1;
        end else begin
          want = samples_due.pop_front();
          if (want != got) begin
            if (errors_o < 10)
              $display("mismatch: mag %h/%h c %h %h %h %h / %h %h %h %h status %0d/%0d",
                       want.mag, got.mag, want.color[0], want.color[1], want.color[2],
                       want.color[3], got.color[0], got.color[1], got.color[2],
                       got.color[3], want.status, got.status);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i <= CFG_MEAN_3) mean_q[cfg_idx_i] = cfg_wdata_i;
        else spread_q[cfg_idx_i - CFG_SPREAD_0] = cfg_wdata_i;
      end
      if (start_i && !busy_i) begin
        if (op_i == OP_LOAD) begin
          if (int'(entry_index_i) < DEPTH) begin
            cdf_q[entry_index_i] = cdf_value_i;
            mag_q[entry_index_i] = mag_value_i;
          end
        end else begin
          samples_due.push_back(shape_draw(uniform_sample_i, gauss_i));
        end
      end
    end
  end
endmodule

// ===== test/inverse_cdf_table_sampler_test.sv =====
// Top of the inverse CDF sampler testbench: clock, reset, table loads, draws and config.
// Depends on icts_pkg, inverse_cdf_table_sampler and inverse_cdf_table_sampler_checker.
module inverse_cdf_table_sampler_test;
  import icts_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [24:0] CDF_ONE = 25'h1000000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic               op_i = OP_LOAD;
  logic [9:0]         entry_index_i = '0;
  logic [24:0]        cdf_value_i = '0;
  logic signed [31:0] mag_value_i = '0;
  logic [23:0]        uniform_sample_i = '0;
  logic [3:0][15:0]   gauss_i = '0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_idx_i = '0;
  logic [31:0]        cfg_wdata_i = '0;
  logic               valid_o;
  logic signed [31:0] magnitude_o;
  logic [3:0][31:0]   color_o;
  logic [1:0]         status_o;
  int                 errors, pending, cycles;
  int                 n_loads, n_draws, n_settings;
  logic [24:0]        cdf_shadow [DEPTH];

  inverse_cdf_table_sampler dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .op_i, .entry_index_i, .cdf_value_i,
    .mag_value_i, .uniform_sample_i,
    .gauss_0_i(gauss_i[0]), .gauss_1_i(gauss_i[1]),
    .gauss_2_i(gauss_i[2]), .gauss_3_i(gauss_i[3]),
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .valid_o, .magnitude_o,
    .color_out_0_o(color_o[0]), .color_out_1_o(color_o[1]),
    .color_out_2_o(color_o[2]), .color_out_3_o(color_o[3]), .status_o
  );

  inverse_cdf_table_sampler_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .op_i, .entry_index_i, .cdf_value_i,
    .mag_value_i, .uniform_sample_i, .gauss_i, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .valid_i(valid_o), .magnitude_i(magnitude_o), .color_i(color_o),
    .status_i(status_o), .errors_o(errors), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d samples outstanding", cycles, pending);
      $display("FAIL inverse_cdf_table_sampler");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic issue(logic op, logic [9:0] idx, logic [24:0] cdf, logic [31:0] mag,
                       logic [23:0] u, logic [3:0][15:0] g);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    op_i <= op;
    entry_index_i <= idx;
    cdf_value_i <= cdf;
    mag_value_i <= mag;
    uniform_sample_i <= u;
    gauss_i <= g;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
    if (op == OP_LOAD) begin
      cdf_shadow[idx] = cdf;
      n_loads++;
    end else begin
      n_draws++;
    end
  endtask

  function automatic logic [3:0][15:0] rand_gauss();
    logic [3:0][15:0] g;
    for (int k = 0; k < 4; k++)
      case ($urandom_range(0, 7))
        0: g[k] = 16'h7fff;
        1: g[k] = 16'h8000;
        default: g[k] = 16'($urandom);
      endcase
    return g;
  endfunction

  task automatic draw(logic [23:0] u, logic [3:0][15:0] g);
    issue(OP_DRAW, 10'($urandom), 25'($urandom), $urandom, u, g);
  endtask

  // reload one entry with a value between its neighbors so the table stays monotone
  task automatic reload_entry();
    int j;
    logic [24:0] lo, hi;
    j = $urandom_range(0, DEPTH - 1);
    lo = j > 0 ? cdf_shadow[j-1] : '0;
    hi = j < DEPTH - 1 ? cdf_shadow[j+1] : CDF_ONE;
    issue(OP_LOAD, 10'(j), lo + 25'($urandom_range(0, int'(hi - lo))), $urandom,
          24'($urandom), rand_gauss());
  endtask

  task automatic random_draw();
    logic [23:0] u;
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) u = 24'($urandom);
    else if (r < 8) u = 24'(cdf_shadow[$urandom_range(0, DEPTH - 1)] +
                           25'($urandom_range(0, 2)) - 25'd1);
    else if (r == 8) u = '0;
    else u = 24'hffffff;
    draw(u, rand_gauss());
  endtask

  // only with start low and every sample delivered; loads leave no trace, so pad
  task automatic configure(logic [3:0][31:0] means, logic [3:0][31:0] spreads);
    start_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
    for (int k = 0; k < 8; k++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= 3'(k);
      cfg_wdata_i <= k <= int'(CFG_MEAN_3) ? means[k] : spreads[k - int'(CFG_SPREAD_0)];
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  initial begin
    logic [3:0][31:0] means, spreads;
    logic [24:0] c;
    cycles = 0;
    n_loads = 0;
    n_draws = 0;
    n_settings = 0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int k = 0; k < 4; k++) begin
      means[k] = $urandom;
      spreads[k] = $urandom_range(0, 32'h0003ffff);
    end
    configure(means, spreads);

    // fill the whole table, increasing, with a few flat steps; last entry at one
    for (int i = 0; i < DEPTH; i++) begin
      if (i == DEPTH - 1) c = CDF_ONE;
      else if (i % 97 == 50) c = cdf_shadow[i-1];
      else c = 25'((i + 1) * 16384 - $urandom_range(1, 8191));
      issue(OP_LOAD, 10'(i), c, $urandom, 24'($urandom), rand_gauss());
    end

    // directed draws: below the first entry, on entries, top of range, gauss extremes
    draw(24'h0, {16'h7fff, 16'h8000, 16'h0000, 16'hffff});
    draw(24'(cdf_shadow[0] - 1), {16'h8000, 16'h7fff, 16'hffff, 16'h0000});
    draw(24'(cdf_shadow[0]), {16'h1000, 16'hf000, 16'h0001, 16'h8001});
    draw(24'(cdf_shadow[50]), rand_gauss());
    draw(24'(cdf_shadow[500] - 1), rand_gauss());
    draw(24'(cdf_shadow[1022]), rand_gauss());
    draw(24'hffffff, {4{16'h7fff}});
    draw(24'hffffff, {4{16'h8000}});
    // drop the last entry to its neighbor: top of range now finds nothing
    issue(OP_LOAD, 10'(DEPTH - 1), cdf_shadow[DEPTH-2], 32'h8000_0000, '0, '0);
    draw(24'hffffff, rand_gauss());
    draw(24'(cdf_shadow[DEPTH-2]), rand_gauss());
    draw(24'(cdf_shadow[DEPTH-2] - 1), rand_gauss());
    issue(OP_LOAD, 10'(DEPTH - 1), CDF_ONE, 32'h7fff_ffff, '0, '0);
    draw(24'hfffffe, rand_gauss());

    for (int phase = 0; phase < 4; phase++) begin
      for (int k = 0; k < 4; k++) begin
        case (phase)
          0: begin means[k] = 32'h7fff_ffff; spreads[k] = 32'hffff_ffff; end
          1: begin means[k] = 32'h8000_0000; spreads[k] = 32'hffff_ffff; end
          2: begin means[k] = $urandom;      spreads[k] = 32'h0; end
          default: begin means[k] = $urandom; spreads[k] = $urandom; end
        endcase
      end
      configure(means, spreads);
      for (int n = 0; n < 150; n++)
        if ($urandom_range(0, 9) < 3) reload_entry();
        else random_draw();
    end

    start_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    $display("sent %0d table loads and %0d draws over %0d register settings",
             n_loads, n_draws, n_settings);
    $display("%0d mismatches", errors);
    if (errors == 0) $display("PASS inverse_cdf_table_sampler");
    else $display("FAIL inverse_cdf_table_sampler");
    $finish;
  end
endmodule
